### rtl/core/subarray_target_sum_search_unit_defines.svh
// ---------------------------------------------------------------------------
// subarray target sum search assertion macros
// shared concurrent assertion forms for the search unit
// ---------------------------------------------------------------------------
`ifndef SUBARRAY_TARGET_SUM_SEARCH_UNIT_DEFINES_SVH
`define SUBARRAY_TARGET_SUM_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTH
`define STS_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");
`define STS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define STS_ASSERT_SAME(label, clk, rst, a, b)
`define STS_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

### rtl/core/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// shared types and constants of the subarray target sum search unit
// ---------------------------------------------------------------------------
package sts_pkg;

   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_BUCKET_WAYS   = 4;
   localparam int DEF_MAX_ITEMS     = 65536;

   localparam int KEY_W = 48;
   localparam int EPOS_W = 16;
   localparam int GEN_W = 8;
   localparam int POS_W = 17;

   localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
   localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

   typedef struct packed {
      logic [GEN_W-1:0]  gen;
      logic [EPOS_W-1:0] pos;
      logic [KEY_W-1:0]  key;
   } entry_type;

   typedef enum logic [2:0] {
      STS_SEARCH        = 3'd0,
      STS_FOUND_NOW     = 3'd1,
      STS_FOUND_EARLIER = 3'd2,
      STS_BUCKET_FULL   = 3'd3,
      STS_POS_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EVAL,
      ST_HASH,
      ST_LOOK_RD,
      ST_LOOK_CHK,
      ST_INS_RD,
      ST_INS_WR
   } state_type;

endpackage

### rtl/core/subarray_target_sum_search_unit.sv
// ---------------------------------------------------------------------------
// subarray_target_sum_search_unit
// prefix-sum search for a contiguous run summing exactly to a target, hashed bucket table
// ---------------------------------------------------------------------------
// flow: an item ends at evaluation if it needs no table access; else it is hashed (with
//   a modulo step for a non-power-of-two set count), its lookup row read and checked, and
//   on a miss its insert row read and written unless the bucket is full
// intake: one word at a time, in idle after the last result moved to the output word
// reset: synchronous; sweeps all TABLE_ENTRIES/BUCKET_WAYS rows, one a cycle,
//   before the first word is taken; a generation wrap repeats the sweep
`include "subarray_target_sum_search_unit_defines.svh"

module subarray_target_sum_search_unit
   import sts_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int BUCKET_WAYS   = DEF_BUCKET_WAYS,
   parameter int MAX_ITEMS     = DEF_MAX_ITEMS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_value
   input  logic        req_tuser,   // first_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, before_start, end_position, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam int NUM_SETS = TABLE_ENTRIES / BUCKET_WAYS;
   localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

   state_type state_ff, state_in;

   logic [31:0]        target_ff;
   logic [31:0]        sample_ff;
   logic [KEY_W-1:0]   prefix_ff, look_key_ff;
   logic [POS_W-1:0]   pos_ff, fbefore_ff, fend_ff;
   logic               done_ff, pend_ff;
   logic [GEN_W-1:0]   gen_ff;
   logic [SET_W-1:0]   sweep_ff, set_look_ff, set_ins_ff;
   status_type         res_status_ff, rsp_status_ff;
   logic [POS_W-1:0]   res_before_ff, res_end_ff, rsp_before_ff, rsp_end_ff;
   logic               res_ready_ff, rsp_valid_ff;

   logic [KEY_W-1:0]   tgt48, new_prefix, new_look;
   logic               overflow, eq_tgt, sweep_last, resp_load, found_load;
   logic               hash_start, look_done, ins_done;
   logic [SET_W-1:0]   look_set, ins_set;
   logic               tbl_rd, tbl_wr;
   logic [SET_W-1:0]   tbl_rd_addr, tbl_wr_addr;
   entry_type [BUCKET_WAYS-1:0] rd_row, wr_row, ins_row;
   logic               look_hit, ins_match, ins_free;
   logic [EPOS_W-1:0]  look_pos;

   assign tgt48      = {{(KEY_W-32){target_ff[31]}}, target_ff};
   assign new_prefix = prefix_ff + {{(KEY_W-32){sample_ff[31]}}, sample_ff};
   assign new_look   = new_prefix - tgt48;
   assign overflow   = pos_ff >= POS_W'(MAX_ITEMS);
   assign eq_tgt     = new_prefix == tgt48;
   assign sweep_last = sweep_ff == SET_W'(NUM_SETS - 1);
   // a finished result moves to the output word when that word is empty or being accepted
   assign resp_load  = res_ready_ff && (!rsp_valid_ff || rsp_tready);
   assign found_load = resp_load && res_status_ff == STS_FOUND_NOW;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_end_ff, rsp_before_ff, rsp_status_ff};

   // lookup and insert scans over the ways of the row just read
   always_comb begin
      look_hit  = 1'b0;
      look_pos  = '0;
      ins_match = 1'b0;
      ins_free  = 1'b0;
      ins_row   = rd_row;
      for (int w = 0; w < BUCKET_WAYS; w++) begin
         if (!look_hit && rd_row[w].gen == gen_ff && rd_row[w].key == look_key_ff) begin
            look_hit = 1'b1;
            look_pos = rd_row[w].pos;
         end
      end
      for (int w = 0; w < BUCKET_WAYS; w++) begin
         if (!ins_match && rd_row[w].gen == gen_ff && rd_row[w].key == prefix_ff) begin
            ins_match      = 1'b1;
            ins_row[w].pos = pos_ff[EPOS_W-1:0];
         end
      end
      if (!ins_match) begin
         for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!ins_free && rd_row[w].gen != gen_ff) begin
               ins_free   = 1'b1;
               ins_row[w] = '{gen: gen_ff, pos: pos_ff[EPOS_W-1:0], key: prefix_ff};
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !res_ready_ff) begin
               state_in = (req_tuser && gen_ff == '1) ? ST_SWEEP : ST_EVAL;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = pend_ff ? ST_EVAL : ST_IDLE;
            end
         end
         ST_EVAL: begin
            state_in = (done_ff || overflow || eq_tgt) ? ST_IDLE : ST_HASH;
         end
         ST_HASH:     state_in = look_done ? ST_LOOK_RD : ST_HASH;
         ST_LOOK_RD:  state_in = ST_LOOK_CHK;
         ST_LOOK_CHK: state_in = look_hit ? ST_IDLE : ST_INS_RD;
         ST_INS_RD:   state_in = ST_INS_WR;
         ST_INS_WR:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready  = 1'b0;
      hash_start  = 1'b0;
      tbl_rd      = 1'b0;
      tbl_rd_addr = set_look_ff;
      tbl_wr      = 1'b0;
      tbl_wr_addr = set_ins_ff;
      wr_row      = ins_row;
      case (state_ff)
         ST_IDLE:    req_tready = !res_ready_ff;
         ST_SWEEP: begin
            tbl_wr      = 1'b1;
            tbl_wr_addr = sweep_ff;
            wr_row      = '0;
         end
         ST_EVAL:    hash_start = !(done_ff || overflow || eq_tgt);
         ST_LOOK_RD: tbl_rd = 1'b1;
         ST_INS_RD: begin
            tbl_rd      = 1'b1;
            tbl_rd_addr = set_ins_ff;
         end
         ST_INS_WR:  tbl_wr = ins_match || ins_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         gen_ff       <= GEN_W'(1);
         target_ff    <= '0;
         prefix_ff    <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         fbefore_ff   <= '1;
         fend_ff      <= '1;
         res_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            target_ff <= csr_wdata;
         end
         if (resp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_before_ff <= res_before_ff;
            rsp_end_ff    <= res_end_ff;
            res_ready_ff  <= 1'b0;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  sample_ff <= req_tdata;
                  if (req_tuser) begin
                     prefix_ff  <= '0;
                     pos_ff     <= '0;
                     done_ff    <= 1'b0;
                     fbefore_ff <= '1;
                     fend_ff    <= '1;
                     if (gen_ff == '1) begin
                        gen_ff   <= GEN_W'(1);
                        sweep_ff <= '0;
                        pend_ff  <= 1'b1;
                     end else begin
                        gen_ff <= gen_ff + GEN_W'(1);
                     end
                  end
               end
            end
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + SET_W'(1);
               if (sweep_last) begin
                  pend_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               res_before_ff <= '1;
               res_end_ff    <= '1;
               if (done_ff) begin
                  res_ready_ff  <= 1'b1;
                  res_status_ff <= STS_FOUND_EARLIER;
                  res_before_ff <= fbefore_ff;
                  res_end_ff    <= fend_ff;
               end else if (overflow) begin
                  res_ready_ff  <= 1'b1;
                  res_status_ff <= STS_POS_OVERFLOW;
               end else begin
                  prefix_ff   <= new_prefix;
                  look_key_ff <= new_look;
                  if (eq_tgt) begin
                     res_ready_ff  <= 1'b1;
                     res_status_ff <= STS_FOUND_NOW;
                     res_end_ff    <= pos_ff;
                     done_ff       <= 1'b1;
                     fbefore_ff    <= '1;
                     fend_ff       <= pos_ff;
                     pos_ff        <= pos_ff + POS_W'(1);
                  end
               end
            end
            ST_HASH: begin
               if (look_done) begin
                  set_look_ff <= look_set;
                  set_ins_ff  <= ins_set;
               end
            end
            ST_LOOK_CHK: begin
               if (look_hit) begin
                  res_ready_ff  <= 1'b1;
                  res_status_ff <= STS_FOUND_NOW;
                  res_before_ff <= {1'b0, look_pos};
                  res_end_ff    <= pos_ff;
                  done_ff       <= 1'b1;
                  fbefore_ff    <= {1'b0, look_pos};
                  fend_ff       <= pos_ff;
                  pos_ff        <= pos_ff + POS_W'(1);
               end
            end
            ST_INS_WR: begin
               res_ready_ff  <= 1'b1;
               res_status_ff <= (ins_match || ins_free) ? STS_SEARCH : STS_BUCKET_FULL;
               pos_ff        <= pos_ff + POS_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   sts_hash #(.NUM_SETS(NUM_SETS), .SET_W(SET_W)) u_hash_look (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (new_look),
      .done    (look_done),
      .set_idx (look_set)
   );

   sts_hash #(.NUM_SETS(NUM_SETS), .SET_W(SET_W)) u_hash_ins (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (new_prefix),
      .done    (ins_done),
      .set_idx (ins_set)
   );

   sts_table #(.NUM_SETS(NUM_SETS), .BUCKET_WAYS(BUCKET_WAYS), .SET_W(SET_W)) u_table (
      .clock   (clock),
      .rd_en   (tbl_rd),
      .rd_addr (tbl_rd_addr),
      .rd_row  (rd_row),
      .wr_en   (tbl_wr),
      .wr_addr (tbl_wr_addr),
      .wr_row  (wr_row)
   );

   `STS_ASSERT_SAME(a_hash_in_step, clock, reset, look_done, ins_done)
   `STS_ASSERT_SAME(a_gen_nonzero, clock, reset, state_ff != ST_SWEEP, gen_ff != '0)
   `STS_ASSERT_NEXT(a_found_latches, clock, reset, found_load, done_ff)

endmodule

### rtl/core/sts_hash.sv
// ---------------------------------------------------------------------------
// sts_hash
// multi-cycle bucket hash: xor-shift, split 64-bit multiply, set modulo
// ---------------------------------------------------------------------------
module sts_hash
   import sts_pkg::*;
#(
   parameter int NUM_SETS = DEF_TABLE_ENTRIES / DEF_BUCKET_WAYS,
   parameter int SET_W    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_W-1:0]     key,
   output logic                 done,
   output logic [SET_W-1:0]     set_idx
);

   localparam bit IS_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;
   localparam int MOD_STEPS = IS_POW2 ? 0 : 3;
   localparam int DONE_CNT  = 2 + MOD_STEPS;
   // reciprocal of the set count scaled by 2^32, quotient estimate is low by at most one
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(NUM_SETS));

   logic                busy_ff;
   logic [5:0]          cnt_ff;
   logic [KEY_W-1:0]    x_ff;
   logic [55:0]         p0_ff, p1_ff, p2_ff;
   logic [7:0]          p3_ff;
   logic [31:0]         hi_ff;
   logic [63:0]         prod_ff;
   logic [31:0]         rem_ff;
   logic [63:0]         sum_in;

   always_comb begin
      sum_in = 64'(p0_ff) + (64'(p1_ff) << 24) + (64'(p2_ff) << 32) + ({p3_ff, 56'd0});
   end

   assign done    = busy_ff && (cnt_ff == 6'(DONE_CNT));
   assign set_idx = IS_POW2 ? SET_W'(hi_ff & 32'(NUM_SETS - 1)) : rem_ff[SET_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         x_ff    <= key ^ (key >> 17);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (done) begin
            busy_ff <= 1'b0;
         end
         if (cnt_ff == 6'd0) begin
            p0_ff <= x_ff[23:0] * HASH_MUL_LO;
            p1_ff <= x_ff[47:24] * HASH_MUL_LO;
            p2_ff <= x_ff[23:0] * HASH_MUL_HI;
            p3_ff <= x_ff[31:24] * HASH_MUL_HI[7:0];
         end else if (cnt_ff == 6'd1) begin
            hi_ff <= sum_in[63:32];
         end else if (!done) begin
            if (cnt_ff == 6'd2) begin
               prod_ff <= hi_ff * RECIP;
            end else if (cnt_ff == 6'd3) begin
               rem_ff <= hi_ff - prod_ff[63:32] * 32'(NUM_SETS);
            end else if (rem_ff >= 32'(NUM_SETS)) begin
               rem_ff <= rem_ff - 32'(NUM_SETS);
            end
         end
      end
   end

endmodule

### rtl/core/sts_table.sv
// ---------------------------------------------------------------------------
// sts_table
// bucket memory: one row per set holding all ways, synchronous registered read latency
// ---------------------------------------------------------------------------
module sts_table
   import sts_pkg::*;
#(
   parameter int NUM_SETS    = DEF_TABLE_ENTRIES / DEF_BUCKET_WAYS,
   parameter int BUCKET_WAYS = DEF_BUCKET_WAYS,
   parameter int SET_W       = 8
) (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [SET_W-1:0]                  rd_addr,
   output entry_type [BUCKET_WAYS-1:0]       rd_row,
   input  logic                              wr_en,
   input  logic [SET_W-1:0]                  wr_addr,
   input  entry_type [BUCKET_WAYS-1:0]       wr_row
);

   entry_type [BUCKET_WAYS-1:0] mem [NUM_SETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row <= mem[rd_addr];
      end
   end

endmodule
